### design/taes_pkg.sv
`default_nettype none

package taes_pkg;

	localparam int DEPTH     = 16;
	localparam int NUM_DET   = 7;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DET_W     = 3;
	localparam int RAW_W     = 62;
	localparam int TIME_W    = 63;
	localparam int CORR_W    = RAW_W + 2;
	localparam int TAG_W     = 16;
	localparam int CFG_W     = 21;
	localparam int CFG_IDX_W = $clog2(NUM_DET + 1);
	localparam int WIN_IDX   = NUM_DET;

	localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

	typedef struct packed {
		logic signed [TIME_W-1:0] time_ns;
		logic [DET_W-1:0]         det;
		logic [TAG_W-1:0]         tag;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_KEEP,
		CELL_INSERT,
		CELL_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   ins;
	} cell_cmd_t;

endpackage

`default_nettype wire

### design/taes_in_if.sv
`default_nettype none

interface taes_in_if import taes_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [DET_W-1:0]  det;
	logic [RAW_W-1:0]  time_ns;
	logic [TAG_W-1:0]  tag;

	modport source (output valid, func, det, time_ns, tag, input ready);
	modport sink   (input valid, func, det, time_ns, tag, output ready);
endinterface

`default_nettype wire

### design/taes_out_if.sv
`default_nettype none

interface taes_out_if import taes_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [TAG_W-1:0]         out_tag;
	logic [DET_W-1:0]         out_det;
	logic signed [TIME_W-1:0] out_time_ns;
	logic                     forced;
	logic                     last;

	modport source (output valid, out_tag, out_det, out_time_ns, forced, last, input ready);
	modport sink   (input valid, out_tag, out_det, out_time_ns, forced, last, output ready);
endinterface

`default_nettype wire

### design/taes_cell.sv
`default_nettype none

module taes_cell import taes_pkg::*; (
	input  wire logic      clk,
	input  wire cell_cmd_t cmd,
	input  wire logic      occ,
	input  wire logic      gt_left,
	input  wire entry_t    left,
	input  wire entry_t    right,
	output logic           gt,
	output entry_t         data
);

	entry_t data_q;

	// empty cells count as later than anything
	assign gt   = !occ || (data_q.time_ns > cmd.ins.time_ns);
	assign data = data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (gt) begin
					data_q <= gt_left ? left : cmd.ins;
				end
			end
			CELL_POP: begin
				data_q <= right;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### design/time_aligned_event_sorter.sv
// sequence: the accepted item's timestamp is corrected and registered, then the item is
// inserted (when the buffer is full, its head or the newcomer itself is forced out first),
// then items past the window are released and the item closes; a flush releases every
// held item. results pass a hold register and leave through an output register, and an
// output stall holds the sequence.
// reset (arst_n low, asynchronous): buffer empty, shifts and window zero, no item pending.
`default_nettype none

module time_aligned_event_sorter import taes_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	taes_in_if.sink                   evt,
	taes_out_if.source                res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_WIN,
		ST_FLUSH
	} state_t;

	// configuration registers
	logic signed [CFG_W-1:0] shift_q [NUM_DET];
	logic [CFG_W-1:0]        window_q;

	// control and working registers
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic signed [TIME_W-1:0] tail_q;   // time of the latest held item
	entry_t            new_s1;          // corrected incoming item

	// one result held back until we know whether it is the last of its item
	logic              hold_v_q;
	entry_t            hold_q;
	logic              hold_forced_q;

	// output register
	logic              out_v_q;
	entry_t            out_q;
	logic              out_forced_q;
	logic              out_last_q;

	// cell row
	cell_cmd_t         cmd;
	entry_t            cell_data [DEPTH];
	logic              cell_gt   [DEPTH];

	logic signed [CFG_W-1:0]  shift_sel;
	logic signed [CORR_W-1:0] corr;
	logic signed [TIME_W-1:0] corr_sat;
	logic signed [CORR_W-1:0] span;
	logic signed [CORR_W-1:0] win_ext;
	entry_t                   head;

	logic out_free, prod_ok, full, new_first, win_hit;
	logic prod_fire, prod_forced, fin_try, fin_fire;
	entry_t prod_e;

	// configuration writes; an index past the window register does nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DET; i++) begin
				shift_q[i] <= '0;
			end
			window_q <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_DET; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					shift_q[i] <= cfg_data;
				end
			end
			if (cfg_index == CFG_IDX_W'(WIN_IDX)) begin
				window_q <= cfg_data;
			end
		end
	end

	// shift lookup: unknown detector numbers use no shift
	always_comb begin
		shift_sel = '0;
		for (int i = 0; i < NUM_DET; i++) begin
			if ({1'b0, evt.det} == (DET_W+1)'(i + 1)) begin
				shift_sel = shift_q[i];
			end
		end
	end

	// corrected time, saturated at the top of the signed range
	assign corr = $signed({2'b00, evt.time_ns}) -
		$signed({{(CORR_W-CFG_W){shift_sel[CFG_W-1]}}, shift_sel});
	assign corr_sat = (corr[CORR_W-1:TIME_W-1] == 2'b01) ? TIME_MAX : corr[TIME_W-1:0];

	assign head = cell_data[0];

	// window check: latest minus earliest against the window
	assign span    = $signed({tail_q[TIME_W-1], tail_q}) -
		$signed({head.time_ns[TIME_W-1], head.time_ns});
	assign win_ext = $signed({{(CORR_W-CFG_W){1'b0}}, window_q});
	assign win_hit = (count_q >= CNT_W'(2)) && (span >= win_ext);

	assign full      = (count_q == CNT_W'(DEPTH));
	assign new_first = (new_s1.time_ns < head.time_ns);
	assign out_free  = !out_v_q || res.ready;
	assign prod_ok   = !hold_v_q || out_free;

	assign evt.ready = (state_q == ST_IDLE);

	// per-state decisions: what the cells do and whether a result is made
	always_comb begin
		cmd.op      = CELL_KEEP;
		cmd.ins     = new_s1;
		prod_fire   = 1'b0;
		prod_forced = 1'b0;
		prod_e      = head;
		fin_try     = 1'b0;
		case (state_q)
			ST_INS: begin
				if (full) begin
					// earliest of the held items plus the new one leaves early
					prod_fire   = prod_ok;
					prod_forced = 1'b1;
					if (new_first) begin
						prod_e = new_s1;
					end else if (prod_ok) begin
						cmd.op = CELL_POP;
					end
				end else begin
					cmd.op = CELL_INSERT;
				end
			end
			ST_WIN: begin
				if (win_hit) begin
					prod_fire = prod_ok;
					if (prod_ok) begin
						cmd.op = CELL_POP;
					end
				end else begin
					fin_try = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (count_q != '0) begin
					prod_fire = prod_ok;
					if (prod_ok) begin
						cmd.op = CELL_POP;
					end
				end else begin
					fin_try = 1'b1;
				end
			end
			default: begin
			end
		endcase
		fin_fire = fin_try && hold_v_q && out_free;
	end

	// row of cells, each item moves one cell per insert or pop
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   gt_left;
		entry_t left;
		entry_t right;

		assign occ = (count_q > CNT_W'(i));
		if (i == 0) begin : g_first
			assign gt_left = 1'b0;
			assign left    = new_s1;
		end else begin : g_mid
			assign gt_left = cell_gt[i-1];
			assign left    = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = cell_data[i];
		end else begin : g_body
			assign right = cell_data[i+1];
		end

		taes_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.occ     (occ),
			.gt_left (gt_left),
			.left    (left),
			.right   (right),
			.gt      (cell_gt[i]),
			.data    (cell_data[i])
		);
	end

	// sequencer, held result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			tail_q        <= '0;
			new_s1        <= '0;
			hold_v_q      <= 1'b0;
			hold_q        <= '0;
			hold_forced_q <= 1'b0;
			out_v_q       <= 1'b0;
			out_q         <= '0;
			out_forced_q  <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			// output register: a new result pushes the held one out, not last;
			// with nothing more for this item the held result closes it
			if (prod_fire && hold_v_q) begin
				out_v_q      <= 1'b1;
				out_q        <= hold_q;
				out_forced_q <= hold_forced_q;
				out_last_q   <= 1'b0;
			end else if (fin_fire) begin
				out_v_q      <= 1'b1;
				out_q        <= hold_q;
				out_forced_q <= hold_forced_q;
				out_last_q   <= 1'b1;
			end else if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end

			// held result
			if (prod_fire) begin
				hold_v_q      <= 1'b1;
				hold_q        <= prod_e;
				hold_forced_q <= prod_forced;
			end else if (fin_fire) begin
				hold_v_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (evt.valid) begin
						if (evt.func) begin
							state_q <= ST_FLUSH;
						end else begin
							new_s1.time_ns <= corr_sat;
							new_s1.det     <= evt.det;
							new_s1.tag     <= evt.tag;
							state_q        <= ST_INS;
						end
					end
				end
				ST_INS: begin
					if (cmd.op == CELL_INSERT) begin
						count_q <= count_q + CNT_W'(1);
						if (count_q == '0 || new_s1.time_ns >= tail_q) begin
							tail_q <= new_s1.time_ns;
						end
						state_q <= ST_WIN;
					end else if (prod_fire) begin
						if (new_first) begin
							state_q <= ST_WIN;
						end else begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				ST_WIN, ST_FLUSH: begin
					if (cmd.op == CELL_POP) begin
						count_q <= count_q - CNT_W'(1);
					end else if (fin_try && (!hold_v_q || out_free)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = out_v_q;
	assign res.out_tag     = out_q.tag;
	assign res.out_det     = out_q.det;
	assign res.out_time_ns = out_q.time_ns;
	assign res.forced      = out_forced_q;
	assign res.last        = out_last_q;

endmodule

`default_nettype wire

### sim/tb_time_aligned_event_sorter.sv
`default_nettype none

module tb_time_aligned_event_sorter;
	import taes_pkg::*;

	// flush items empty the buffer, event items go through shift and insertion
	typedef enum bit {
		FN_EVENT = 1'b0,
		FN_FLUSH = 1'b1
	} fn_t;

	// one released item as it should appear on the result channel
	typedef struct packed {
		logic [TAG_W-1:0]         tag;
		logic [DET_W-1:0]         det;
		logic signed [TIME_W-1:0] tns;
		logic                     forced;
		logic                     last;
	} result_t;

	// one row of the directed plan; a typed row carries its single known result
	typedef struct packed {
		bit               reload;
		fn_t              fn;
		logic [DET_W-1:0] det;
		logic [RAW_W-1:0] raw;
		logic [TAG_W-1:0] tag;
		int               rep;
		bit               typed;
		result_t          want;
	} step_t;

	// an event held in the sorted buffer, time already corrected
	typedef struct {
		longint           t;
		logic [DET_W-1:0] det;
		logic [TAG_W-1:0] tag;
	} held_t;

	localparam int     PERIOD      = 10;
	localparam int     DRAIN       = 32;
	localparam int     HOLD_CYCLES = 400;
	localparam int     LIMIT       = 600000;
	localparam int     PHASES      = 5;
	localparam int     PHASE_ITEMS = 100;
	localparam int     FILL_STEP   = 7;
	localparam longint TMAX        = longint'(TIME_MAX);

	// extreme register setting used by the directed part: shift range ends,
	// both ends of the documented shift range, window beyond its documented top
	localparam logic [CFG_W-1:0] EXTREME_CFG [NUM_DET+1] = '{
		21'h100000, 21'h0FFFFF, 21'd1000000, CFG_W'(-1000000),
		21'd0, CFG_W'(-7), 21'd1, 21'h1FFFFF
	};

	localparam int PLAN_N = 14;

	// directed plan: reset config first, then the extreme setting from the reload row on
	step_t plan [PLAN_N] = '{
		// lone event after reset, nothing released
		'{1'b0, FN_EVENT, 3'd1, 62'd100, 16'h0001, 1, 1'b0, '0},
		// unknown detector, earlier event, zero window releases it at once
		'{1'b0, FN_EVENT, 3'd0, 62'd50, 16'h0002, 1, 1'b1,
			'{16'h0002, 3'd0, 63'sd50, 1'b0, 1'b1}},
		// equal time goes after the held one, so the held one leaves
		'{1'b0, FN_EVENT, 3'd4, 62'd100, 16'h0003, 1, 1'b1,
			'{16'h0001, 3'd1, 63'sd100, 1'b0, 1'b1}},
		// flush with junk event fields
		'{1'b0, FN_FLUSH, 3'd5, 62'd77, 16'h0009, 1, 1'b1,
			'{16'h0003, 3'd4, 63'sd100, 1'b0, 1'b1}},
		// flush of an empty buffer
		'{1'b0, FN_FLUSH, 3'd0, 62'd0, 16'h0000, 1, 1'b0, '0},
		// top raw time minus the most negative shift saturates
		'{1'b1, FN_EVENT, 3'd1, {RAW_W{1'b1}}, 16'hFFFF, 1, 1'b0, '0},
		// most positive shift drives time below zero, span exceeds the window
		'{1'b0, FN_EVENT, 3'd2, 62'd0, 16'h0202, 1, 1'b1,
			'{16'h0202, 3'd2, -63'sd1048575, 1'b0, 1'b1}},
		'{1'b0, FN_FLUSH, 3'd0, 62'd0, 16'h0000, 1, 1'b1,
			'{16'hFFFF, 3'd1, TIME_MAX, 1'b0, 1'b1}},
		// fill the buffer to the brim
		'{1'b0, FN_EVENT, 3'd0, 62'd1000, 16'h0100, DEPTH, 1'b0, '0},
		// full buffer, newcomer earliest of all: forced out itself
		'{1'b0, FN_EVENT, 3'd0, 62'd5, 16'h0AAA, 1, 1'b1,
			'{16'h0AAA, 3'd0, 63'sd5, 1'b1, 1'b1}},
		// full buffer, newcomer later: held head forced out
		'{1'b0, FN_EVENT, 3'd0, 62'd5000, 16'h0BBB, 1, 1'b1,
			'{16'h0100, 3'd0, 63'sd1000, 1'b1, 1'b1}},
		'{1'b0, FN_EVENT, 3'd3, 62'd2000000, 16'h0C0C, 1, 1'b0, '0},
		'{1'b0, FN_EVENT, 3'd6, 62'd0, 16'h1234, 1, 1'b0, '0},
		'{1'b0, FN_FLUSH, 3'd7, 62'h2AAA_AAAA_AAAA_AAAA, 16'h5555, 1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	taes_in_if  evt();
	taes_out_if res();

	time_aligned_event_sorter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: shifts, window, sorted buffer
	longint  shift_ns [NUM_DET];
	longint  win_ns;
	held_t   held_q [$];
	result_t fresh_q [$];
	result_t due_q [$];

	logic [CFG_W-1:0] cfg_plan [NUM_DET+1];

	// idling controls shared with the result side
	bit calm;
	int hold_req;
	int hold_seen;
	int hold_left;

	int cycles;
	int mismatches;
	int items_in;
	int flushes_in;
	int results_out;
	int forced_out;
	int cfg_writes;

	always begin
		#(PERIOD / 2) clk = 1'b1;
		#(PERIOD / 2) clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout at cycle %0d with %0d results still due",
				cycles, due_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// remove and return the earliest held event
	function automatic held_t take_head();
		held_t e;
		e = held_q[0];
		held_q.delete(0);
		return e;
	endfunction

	// queue one released event into the fresh results of the current item
	function automatic void emit(input held_t e, input bit frc);
		result_t r;
		r.tag    = e.tag;
		r.det    = e.det;
		r.tns    = TIME_W'(e.t);
		r.forced = frc;
		r.last   = 1'b0;
		fresh_q.push_back(r);
	endfunction

	// sorter behavior for one accepted item, results land in fresh_q
	function automatic void forecast(input fn_t fn, input logic [DET_W-1:0] d,
		input logic [RAW_W-1:0] raw, input logic [TAG_W-1:0] g);
		longint t;
		longint sh;
		held_t  e;
		int     pos;
		fresh_q.delete();
		if (fn == FN_FLUSH) begin
			while (held_q.size() > 0)
				emit(take_head(), 1'b0);
		end else begin
			// unknown detectors use no shift
			sh = (d >= 1 && d <= NUM_DET) ? shift_ns[d - 1] : 0;
			t  = longint'({2'b00, raw}) - sh;
			if (t > TMAX)
				t = TMAX;
			e.t   = t;
			e.det = d;
			e.tag = g;
			if (held_q.size() >= DEPTH && t < held_q[0].t) begin
				emit(e, 1'b1);
			end else begin
				if (held_q.size() >= DEPTH)
					emit(take_head(), 1'b1);
				// equal times stay in arrival order
				pos = held_q.size();
				while (pos > 0 && held_q[pos - 1].t > t)
					pos--;
				held_q.insert(pos, e);
			end
			while (held_q.size() >= 2 && held_q[$].t - held_q[0].t >= win_ns)
				emit(take_head(), 1'b0);
		end
		if (fresh_q.size() > 0)
			fresh_q[$].last = 1'b1;
	endfunction

	// offer one item, wait for the handshake, then predict its results
	task automatic run_item(input fn_t fn, input logic [DET_W-1:0] d,
		input logic [RAW_W-1:0] raw, input logic [TAG_W-1:0] g,
		input bit typed, input result_t want);
		if (!calm) begin
			while ($urandom_range(0, 99) < 37) begin
				evt.valid <= 1'b0;
				@(posedge clk);
			end
		end
		evt.valid   <= 1'b1;
		evt.func    <= fn;
		evt.det     <= d;
		evt.time_ns <= raw;
		evt.tag     <= g;
		@(posedge clk);
		while (!evt.ready)
			@(posedge clk);
		items_in++;
		if (fn == FN_FLUSH)
			flushes_in++;
		forecast(fn, d, raw, g);
		if (typed)
			due_q.push_back(want);
		else
			foreach (fresh_q[i])
				due_q.push_back(fresh_q[i]);
	endtask

	// stop offering, let every due result out, then give in-flight items time to finish
	task automatic settle();
		evt.valid <= 1'b0;
		while (due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// write all registers from cfg_plan, one per cycle, and mirror them
	task automatic write_regs();
		for (int i = 0; i <= NUM_DET; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= cfg_plan[i];
			if (i == WIN_IDX)
				win_ns = longint'(cfg_plan[i]);
			else
				shift_ns[i] = longint'($signed(cfg_plan[i]));
			cfg_writes++;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// random shift: range ends, small offsets, or anything the field holds
	function automatic logic [CFG_W-1:0] pick_shift();
		case ($urandom_range(0, 7))
			0: return 21'h100000;
			1: return 21'h0FFFFF;
			2: return 21'd1000000;
			3: return CFG_W'(-1000000);
			7: return CFG_W'($urandom_range(0, 21'h1FFFFF));
			default: return CFG_W'(int'($urandom_range(0, 1000)) - 500);
		endcase
	endfunction

	// result side: random idling, calm stretch, and one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else if (calm) begin
			res.ready <= 1'b1;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= 37);
		end
	end

	// result checker: every accepted result against the oldest due one
	always @(posedge clk) begin
		result_t w;
		if (arst_n && res.valid && res.ready) begin
			results_out++;
			if (res.forced)
				forced_out++;
			if (due_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result tag %h time %0d",
					res.out_tag, res.out_time_ns));
			end else begin
				w = due_q[0];
				due_q.delete(0);
				check_field("out_tag", 64'(res.out_tag), 64'(w.tag));
				check_field("out_det", 64'(res.out_det), 64'(w.det));
				check_field("out_time_ns", 64'(res.out_time_ns), 64'(w.tns));
				check_field("forced", 64'(res.forced), 64'(w.forced));
				check_field("last", 64'(res.last), 64'(w.last));
			end
		end
	end

	initial begin
		logic [RAW_W-1:0] base;
		logic [RAW_W-1:0] t;
		logic [DET_W-1:0] d;
		logic [TAG_W-1:0] g;
		fn_t              fn;
		int               r;

		// every block input known from time zero
		arst_n      = 1'b0;
		evt.valid   = 1'b0;
		evt.func    = FN_EVENT;
		evt.det     = '0;
		evt.time_ns = '0;
		evt.tag     = '0;
		res.ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		calm        = 1'b0;
		hold_req    = 0;
		hold_seen   = 0;
		hold_left   = 0;
		cycles      = 0;
		mismatches  = 0;
		items_in    = 0;
		flushes_in  = 0;
		results_out = 0;
		forced_out  = 0;
		cfg_writes  = 0;
		win_ns      = 0;
		foreach (shift_ns[i])
			shift_ns[i] = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan; the fill row repeats with rising time and tag
		foreach (plan[i]) begin
			if (plan[i].reload) begin
				settle();
				cfg_plan = EXTREME_CFG;
				write_regs();
			end
			for (int k = 0; k < plan[i].rep; k++)
				run_item(plan[i].fn, plan[i].det, plan[i].raw + RAW_W'(FILL_STEP * k),
					plan[i].tag + TAG_W'(k), plan[i].typed, plan[i].want);
		end

		// random phases, each under a fresh register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			foreach (cfg_plan[i])
				cfg_plan[i] = pick_shift();
			case (ph)
				0: cfg_plan[WIN_IDX] = '0;
				1: cfg_plan[WIN_IDX] = CFG_W'($urandom_range(1, 64));
				2: cfg_plan[WIN_IDX] = CFG_W'($urandom_range(64, 3000));
				3: cfg_plan[WIN_IDX] = 21'd2000000;
				default: cfg_plan[WIN_IDX] = CFG_W'($urandom_range(0, 400));
			endcase
			write_regs();

			// near zero, near the top of the raw range, or anywhere
			case (ph)
				0: base = RAW_W'($urandom_range(0, 1000));
				3: base = {RAW_W{1'b1}} - RAW_W'($urandom_range(0, 100000));
				default: base = RAW_W'({$urandom, $urandom});
			endcase

			// phase 0 runs without idling; phase 2 opens with a long hold-off
			calm <= (ph == 0);
			if (ph == 2)
				hold_req <= hold_req + 1;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r  = $urandom_range(0, 99);
				fn = FN_EVENT;
				g  = TAG_W'($urandom);
				d  = DET_W'($urandom_range(1, NUM_DET));
				t  = base + RAW_W'($urandom_range(0, 200));
				if (r < 4) begin
					// flush with random leftovers in the event fields
					fn = FN_FLUSH;
					d  = DET_W'($urandom_range(0, 7));
					t  = RAW_W'({$urandom, $urandom});
				end else if (r < 8) begin
					// stray event anywhere in time
					d = DET_W'($urandom_range(0, 7));
					t = RAW_W'({$urandom, $urandom});
				end else if (r < 12) begin
					d = '0;
				end
				run_item(fn, d, t, g, 1'b0, '0);
				base = base + RAW_W'($urandom_range(0, 30));
			end
			calm <= 1'b0;
		end

		// empty whatever is still held
		run_item(FN_FLUSH, '0, '0, '0, 1'b0, '0);
		settle();

		$display("summary: %0d items in (%0d flushes), %0d results out (%0d forced)",
			items_in, flushes_in, results_out, forced_out);
		$display("summary: %0d register writes, windows zero to full scale, %0d mismatches",
			cfg_writes, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
